[src/ktta_pkg.sv]
// Shared types, constants and fixed-point helpers for the Kalman target tracker.
// Used by every module of the tracker; depends on nothing.
`timescale 1ns / 1ps

package ktta_pkg;

    // Axis count: lanes actually built (x, y, z order); at most three
    localparam int AXES       = 3;
    localparam int FIELD_AXES = 3;

    // Configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_FOCAL_X    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FOCAL_Y    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_X   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Y   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_LATENCY    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_POS_NOISE  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_VEL_NOISE  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_MEAS_NOISE = 3'd7;

    localparam logic [31:0] POS_NOISE_RST  = 32'd66;
    localparam logic [31:0] VEL_NOISE_RST  = 32'd327680;
    localparam logic [31:0] MEAS_NOISE_RST = 32'd66;

    // Fixed-point constants
    localparam logic [31:0]        ONE_Q       = 32'd65536;
    localparam logic [15:0]        DT_DEFAULT  = 16'd1049;
    localparam logic [31:0]        DROPOUT_MS  = 32'd500;
    localparam logic signed [17:0] HALF_PI_Q   = 18'sd102944;
    // ceil(2^40 / 1000): exact for ms counts up to the dropout limit
    localparam logic [30:0]        RECIP_1000  = 31'd1099511628;

    // Divider geometry
    localparam int DIV_NW    = 64;
    localparam int DIV_DW    = 33;
    localparam int DIV_CNT_W = 7;

    localparam int CORDIC_STEPS = 16;
    localparam int CORDIC_W     = 35;

    typedef logic signed [31:0] q32s_t;
    typedef logic signed [49:0] wide_t;

    localparam wide_t S32_MAX = 50'sd2147483647;
    localparam wide_t S32_MIN = -50'sd2147483648;
    localparam wide_t U32_MAX = 50'sd4294967295;

    // Lane-side configuration
    typedef struct packed {
        logic [31:0] pos_noise;
        logic [31:0] vel_noise;
        logic [31:0] meas_noise;
        logic [16:0] latency;
    } lane_cfg_t;

    // Lane control: launch strobe and step parameters
    typedef struct packed {
        logic        start;
        logic        reseed;
        logic [15:0] dt;
    } lane_ctl_t;

    // Projection configuration
    typedef struct packed {
        logic [31:0] focal_x;
        logic [31:0] focal_y;
        logic [31:0] center_x;
        logic [31:0] center_y;
    } proj_cfg_t;

    function automatic wide_t widen_u(input logic [31:0] v);
        return wide_t'({18'd0, v});
    endfunction

    function automatic wide_t widen_s(input q32s_t v);
        return wide_t'(v);
    endfunction

    function automatic q32s_t sat_s32(input wide_t v);
        q32s_t r;
        if (v > S32_MAX) begin
            r = 32'sh7fffffff;
        end else if (v < S32_MIN) begin
            r = 32'sh80000000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    function automatic logic [31:0] clamp_u32(input wide_t v);
        logic [31:0] r;
        if (v < 0) begin
            r = 32'd0;
        end else if (v > U32_MAX) begin
            r = 32'hffffffff;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    // Signed 32-bit view of a quotient magnitude with a sign, saturated
    function automatic q32s_t sat_mag(input logic [63:0] m, input logic neg);
        q32s_t r;
        if (!neg) begin
            r = (m > 64'h7fffffff) ? 32'sh7fffffff : q32s_t'(m[31:0]);
        end else begin
            r = (m > 64'h80000000) ? 32'sh80000000 : q32s_t'(32'd0 - m[31:0]);
        end
        return r;
    endfunction

    // Arctangent of 2^-i in Q16.16
    function automatic logic [16:0] atan_entry(input logic [3:0] i);
        logic [16:0] r;
        unique case (i)
            4'd0:    r = 17'd51472;
            4'd1:    r = 17'd30386;
            4'd2:    r = 17'd16055;
            4'd3:    r = 17'd8150;
            4'd4:    r = 17'd4091;
            4'd5:    r = 17'd2047;
            4'd6:    r = 17'd1024;
            4'd7:    r = 17'd512;
            4'd8:    r = 17'd256;
            4'd9:    r = 17'd128;
            4'd10:   r = 17'd64;
            4'd11:   r = 17'd32;
            4'd12:   r = 17'd16;
            4'd13:   r = 17'd8;
            4'd14:   r = 17'd4;
            default: r = 17'd2;
        endcase
        return r;
    endfunction

endpackage

[src/ktta_div.sv]
// Bit-serial restoring divider, one quotient bit per cycle.
// Depends on ktta_pkg for its widths.
`timescale 1ns / 1ps

module ktta_div (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           start,
    input  logic [ktta_pkg::DIV_NW-1:0]    dividend,
    input  logic [ktta_pkg::DIV_DW-1:0]    divisor,
    output logic                           done,
    output logic [ktta_pkg::DIV_NW-1:0]    quotient
);

    logic                               run_reg;
    logic                               done_reg;
    logic [ktta_pkg::DIV_CNT_W-1:0]     cnt_reg;
    logic [ktta_pkg::DIV_DW-1:0]        rem_reg;
    logic [ktta_pkg::DIV_DW-1:0]        den_reg;
    logic [ktta_pkg::DIV_NW-1:0]        quo_reg;
    logic [ktta_pkg::DIV_DW:0]          trial;
    logic                               fits;

    // Trial subtract of the shifted remainder
    assign trial = {rem_reg, quo_reg[ktta_pkg::DIV_NW-1]};
    assign fits  = (trial >= {1'b0, den_reg});

    // Sequencing
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                run_reg <= 1'b1;
                cnt_reg <= ktta_pkg::DIV_CNT_W'(ktta_pkg::DIV_NW);
            end else if (run_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == ktta_pkg::DIV_CNT_W'(1)) begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath: dividend shifts out as quotient bits shift in
    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= '0;
            den_reg <= divisor;
            quo_reg <= dividend;
        end else if (run_reg) begin
            rem_reg <= fits ? ktta_pkg::DIV_DW'(trial - {1'b0, den_reg})
                            : trial[ktta_pkg::DIV_DW-1:0];
            quo_reg <= {quo_reg[ktta_pkg::DIV_NW-2:0], fits};
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

[src/ktta_cordic.sv]
// Vectoring CORDIC: atan(y/x) for x > 0, one rotation per cycle, clamped.
// Depends on ktta_pkg for the angle table and widths.
`timescale 1ns / 1ps

module ktta_cordic (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  start,
    input  ktta_pkg::q32s_t       x_in,
    input  ktta_pkg::q32s_t       y_in,
    output logic                  busy,
    output logic signed [17:0]    angle
);

    logic                                   run_reg;
    logic [3:0]                             i_reg;
    logic signed [ktta_pkg::CORDIC_W-1:0]   x_reg;
    logic signed [ktta_pkg::CORDIC_W-1:0]   y_reg;
    logic signed [17:0]                     ang_reg;
    logic signed [ktta_pkg::CORDIC_W-1:0]   xs;
    logic signed [ktta_pkg::CORDIC_W-1:0]   ys;
    logic signed [17:0]                     step_ang;

    assign xs       = x_reg >>> i_reg;
    assign ys       = y_reg >>> i_reg;
    assign step_ang = $signed({1'b0, ktta_pkg::atan_entry(i_reg)});

    // Step counter
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg <= 1'b0;
            i_reg   <= '0;
        end else if (start) begin
            run_reg <= 1'b1;
            i_reg   <= '0;
        end else if (run_reg) begin
            i_reg <= i_reg + 1'b1;
            if (i_reg == 4'(ktta_pkg::CORDIC_STEPS - 1)) begin
                run_reg <= 1'b0;
            end
        end
    end

    // Rotation; a zero residual leaves everything as is
    always_ff @(posedge aclk) begin
        if (start) begin
            x_reg   <= ktta_pkg::CORDIC_W'(x_in);
            y_reg   <= ktta_pkg::CORDIC_W'(y_in);
            ang_reg <= '0;
        end else if (run_reg) begin
            if (y_reg > 0) begin
                x_reg   <= x_reg + ys;
                y_reg   <= y_reg - xs;
                ang_reg <= ang_reg + step_ang;
            end else if (y_reg < 0) begin
                x_reg   <= x_reg - ys;
                y_reg   <= y_reg + xs;
                ang_reg <= ang_reg - step_ang;
            end
        end
    end

    // Clamp to a quarter turn
    always_comb begin
        if (ang_reg > ktta_pkg::HALF_PI_Q) begin
            angle = ktta_pkg::HALF_PI_Q;
        end else if (ang_reg < -ktta_pkg::HALF_PI_Q) begin
            angle = -ktta_pkg::HALF_PI_Q;
        end else begin
            angle = ang_reg;
        end
    end

    assign busy = run_reg;

endmodule

[src/ktta_lane.sv]
// One axis of the tracker: position/velocity Kalman predict and correct,
// then latency extrapolation. One shared multiplier and a serial divider.
// Depends on ktta_pkg and ktta_div.
`timescale 1ns / 1ps

module ktta_lane (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  ktta_pkg::lane_ctl_t   ctl,
    input  ktta_pkg::lane_cfg_t   cfg,
    input  ktta_pkg::q32s_t       meas,
    output logic                  done,
    output ktta_pkg::q32s_t       pred
);

    // Sequencer states
    localparam logic [2:0] ST_IDLE    = 3'd0;
    localparam logic [2:0] ST_MUL     = 3'd1;
    localparam logic [2:0] ST_WB      = 3'd2;
    localparam logic [2:0] ST_DIVGO   = 3'd3;
    localparam logic [2:0] ST_DIVWAIT = 3'd4;

    // Operation order
    localparam logic [3:0] OP_DV  = 4'd0;   // dt * v
    localparam logic [3:0] OP_DB  = 4'd1;   // dt * b
    localparam logic [3:0] OP_DC  = 4'd2;   // dt * c
    localparam logic [3:0] OP_DDC = 4'd3;   // dt * (dt * c)
    localparam logic [3:0] OP_K1  = 4'd4;   // gain a'/S
    localparam logic [3:0] OP_K2  = 4'd5;   // gain b'/S
    localparam logic [3:0] OP_K1E = 4'd6;
    localparam logic [3:0] OP_K2E = 4'd7;
    localparam logic [3:0] OP_K1A = 4'd8;
    localparam logic [3:0] OP_K1B = 4'd9;
    localparam logic [3:0] OP_K2B = 4'd10;
    localparam logic [3:0] OP_NL  = 4'd11;  // v * latency

    logic [2:0]             st_reg;
    logic [3:0]             op_reg;
    logic                   done_reg;

    // Filter state
    ktta_pkg::q32s_t        pos_reg;
    ktta_pkg::q32s_t        vel_reg;
    ktta_pkg::q32s_t        ccov_reg;
    logic [31:0]            pvar_reg;
    logic [31:0]            vvar_reg;

    // Per-item working values
    ktta_pkg::q32s_t        z_reg;
    logic [15:0]            dt_reg;
    logic signed [33:0]     pp_reg;
    ktta_pkg::q32s_t        e_reg;
    logic signed [32:0]     tdb_reg;
    logic [31:0]            tdc_reg;
    logic [31:0]            ap_reg;
    ktta_pkg::q32s_t        bp_reg;
    logic [31:0]            cp_reg;
    logic [16:0]            k1_reg;
    ktta_pkg::q32s_t        k2_reg;
    ktta_pkg::q32s_t        pred_reg;
    logic [63:0]            prod_reg;
    logic                   neg_reg;

    logic signed [32:0]     opa;
    logic signed [32:0]     opb;
    logic [31:0]            mag_a;
    logic [31:0]            mag_b;
    logic [64:0]            rsum;
    ktta_pkg::wide_t        rres;
    logic [32:0]            s_sum;
    logic [31:0]            bp_mag;
    logic [63:0]            div_num;
    logic                   div_start;
    logic                   div_done;
    logic [63:0]            div_q;
    logic                   s_zero;
    logic                   k_done;

    // Operand selection
    always_comb begin
        unique case (op_reg)
            OP_DV:   begin opa = $signed({17'd0, dt_reg}); opb = 33'(vel_reg);  end
            OP_DB:   begin opa = $signed({17'd0, dt_reg}); opb = 33'(ccov_reg); end
            OP_DC:   begin opa = $signed({17'd0, dt_reg}); opb = $signed({1'b0, vvar_reg}); end
            OP_DDC:  begin opa = $signed({17'd0, dt_reg}); opb = $signed({1'b0, tdc_reg}); end
            OP_K1E:  begin opa = $signed({16'd0, k1_reg}); opb = 33'(e_reg);    end
            OP_K2E:  begin opa = 33'(k2_reg);              opb = 33'(e_reg);    end
            OP_K1A:  begin opa = $signed({16'd0, k1_reg}); opb = $signed({1'b0, ap_reg}); end
            OP_K1B:  begin opa = $signed({16'd0, k1_reg}); opb = 33'(bp_reg);   end
            OP_K2B:  begin opa = 33'(k2_reg);              opb = 33'(bp_reg);   end
            OP_NL:   begin opa = 33'(vel_reg); opb = $signed({16'd0, cfg.latency}); end
            default: begin opa = '0;                       opb = '0;            end
        endcase
    end

    assign mag_a = opa[32] ? 32'(-opa) : opa[31:0];
    assign mag_b = opb[32] ? 32'(-opb) : opb[31:0];

    // Rounded signed product, ties away from zero
    assign rsum = {1'b0, prod_reg} + 65'd32768;
    assign rres = neg_reg ? -ktta_pkg::wide_t'({2'b0, rsum[63:16]})
                          :  ktta_pkg::wide_t'({2'b0, rsum[63:16]});

    // Gain division setup
    assign s_sum   = {1'b0, ap_reg} + {1'b0, cfg.meas_noise};
    assign s_zero  = (s_sum == 33'd0);
    assign bp_mag  = bp_reg[31] ? 32'(-bp_reg) : 32'(bp_reg);
    assign div_num = (op_reg == OP_K1) ? ({16'd0, ap_reg, 16'd0} + 64'(s_sum[32:1]))
                                       : ({16'd0, bp_mag, 16'd0} + 64'(s_sum[32:1]));
    assign div_start = (st_reg == ST_DIVGO) && !s_zero;
    assign k_done    = ((st_reg == ST_DIVGO) && s_zero) ||
                       ((st_reg == ST_DIVWAIT) && div_done);

    ktta_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_num),
        .divisor  (s_sum),
        .done     (div_done),
        .quotient (div_q)
    );

    // Sequencer and filter state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg   <= ST_IDLE;
            op_reg   <= OP_DV;
            done_reg <= 1'b0;
            pos_reg  <= '0;
            vel_reg  <= '0;
            ccov_reg <= '0;
            pvar_reg <= ktta_pkg::ONE_Q;
            vvar_reg <= ktta_pkg::ONE_Q;
        end else begin
            unique case (st_reg)
                ST_IDLE: begin
                    if (ctl.start) begin
                        done_reg <= 1'b0;
                        op_reg   <= OP_DV;
                        st_reg   <= ST_MUL;
                        if (ctl.reseed) begin
                            pos_reg <= meas;
                            vel_reg <= '0;
                        end
                    end
                end
                ST_MUL: begin
                    st_reg <= ST_WB;
                end
                ST_WB: begin
                    op_reg <= op_reg + 1'b1;
                    if (op_reg == OP_DDC) begin
                        st_reg <= ST_DIVGO;
                    end else if (op_reg == OP_NL) begin
                        st_reg   <= ST_IDLE;
                        done_reg <= 1'b1;
                    end else begin
                        st_reg <= ST_MUL;
                    end
                    unique case (op_reg)
                        OP_K1E:  pos_reg  <= ktta_pkg::sat_s32(ktta_pkg::wide_t'(pp_reg) + rres);
                        OP_K2E:  vel_reg  <= ktta_pkg::sat_s32(ktta_pkg::widen_s(vel_reg) + rres);
                        OP_K1A:  pvar_reg <= ktta_pkg::clamp_u32(ktta_pkg::widen_u(ap_reg) - rres);
                        OP_K1B:  ccov_reg <= ktta_pkg::sat_s32(ktta_pkg::widen_s(bp_reg) - rres);
                        OP_K2B:  vvar_reg <= ktta_pkg::clamp_u32(ktta_pkg::widen_u(cp_reg) - rres);
                        default: ;
                    endcase
                end
                ST_DIVGO, ST_DIVWAIT: begin
                    if (st_reg == ST_DIVGO && !s_zero) begin
                        st_reg <= ST_DIVWAIT;
                    end
                    if (k_done) begin
                        if (op_reg == OP_K1) begin
                            op_reg <= OP_K2;
                            st_reg <= ST_DIVGO;
                        end else begin
                            op_reg <= OP_K1E;
                            st_reg <= ST_MUL;
                        end
                    end
                end
                default: st_reg <= ST_IDLE;
            endcase
        end
    end

    // Working values
    always_ff @(posedge aclk) begin
        if (st_reg == ST_IDLE && ctl.start) begin
            z_reg  <= meas;
            dt_reg <= ctl.dt;
        end
        if (st_reg == ST_MUL) begin
            prod_reg <= 64'(mag_a) * 64'(mag_b);
            neg_reg  <= opa[32] ^ opb[32];
        end
        if (st_reg == ST_WB) begin
            unique case (op_reg)
                OP_DV: begin
                    pp_reg <= 34'(ktta_pkg::widen_s(pos_reg) + rres);
                    e_reg  <= ktta_pkg::sat_s32(ktta_pkg::widen_s(z_reg) -
                                                (ktta_pkg::widen_s(pos_reg) + rres));
                end
                OP_DB: tdb_reg <= 33'(rres);
                OP_DC: begin
                    tdc_reg <= rres[31:0];
                    bp_reg  <= ktta_pkg::sat_s32(ktta_pkg::widen_s(ccov_reg) + rres);
                    cp_reg  <= ktta_pkg::clamp_u32(ktta_pkg::widen_u(vvar_reg) +
                                                   ktta_pkg::widen_u(cfg.vel_noise));
                end
                OP_DDC: begin
                    ap_reg <= ktta_pkg::clamp_u32(ktta_pkg::widen_u(pvar_reg) +
                                                  ktta_pkg::wide_t'(tdb_reg) +
                                                  ktta_pkg::wide_t'(tdb_reg) + rres +
                                                  ktta_pkg::widen_u(cfg.pos_noise));
                end
                OP_NL:   pred_reg <= ktta_pkg::sat_s32(ktta_pkg::widen_s(pos_reg) + rres);
                default: ;
            endcase
        end
        // Gains; zero innovation variance gives zero gain
        if (k_done) begin
            if (op_reg == OP_K1) begin
                k1_reg <= s_zero ? 17'd0 : div_q[16:0];
            end else begin
                k2_reg <= s_zero ? 32'sd0 : ktta_pkg::sat_mag(div_q, bp_reg[31]);
            end
        end
    end

    assign done = done_reg;
    assign pred = pred_reg;

endmodule

[src/ktta_merge.sv]
// Merging stage: projects the lane predictions to pixels and forms pan/tilt.
// Depends on ktta_pkg, ktta_div and ktta_cordic.
`timescale 1ns / 1ps

module ktta_merge (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  start,
    input  ktta_pkg::q32s_t       pred [ktta_pkg::FIELD_AXES],
    input  ktta_pkg::proj_cfg_t   cfg,
    output logic                  res_valid,
    input  logic                  res_ready,
    output ktta_pkg::q32s_t       pixel_x,
    output ktta_pkg::q32s_t       pixel_y,
    output logic signed [17:0]    pan_rad,
    output logic signed [17:0]    tilt_rad
);

    localparam logic [2:0] M_IDLE    = 3'd0;
    localparam logic [2:0] M_MUL     = 3'd1;
    localparam logic [2:0] M_DIVGO   = 3'd2;
    localparam logic [2:0] M_DIVWAIT = 3'd3;
    localparam logic [2:0] M_HOLD    = 3'd4;

    logic [2:0]             st_reg;
    logic                   sel_reg;
    logic                   proj_reg;
    logic [63:0]            prod_reg;
    logic                   neg_reg;
    ktta_pkg::q32s_t        px_reg;
    ktta_pkg::q32s_t        py_reg;

    logic                   proj;
    ktta_pkg::q32s_t        p_sel;
    logic [31:0]            p_mag;
    logic [31:0]            focal_sel;
    logic [31:0]            center_sel;
    logic [31:0]            zd;
    logic                   cordic_go;
    logic                   div_start;
    logic                   div_done;
    logic [63:0]            div_q;
    ktta_pkg::wide_t        q_signed;
    ktta_pkg::q32s_t        pix;
    logic                   pan_busy;
    logic                   tilt_busy;
    logic signed [17:0]     pan_raw;
    logic signed [17:0]     tilt_raw;

    assign proj       = (pred[2] > $signed(ktta_pkg::ONE_Q));
    assign zd         = pred[2];
    assign p_sel      = sel_reg ? pred[1] : pred[0];
    assign p_mag      = p_sel[31] ? 32'(-p_sel) : 32'(p_sel);
    assign focal_sel  = sel_reg ? cfg.focal_y : cfg.focal_x;
    assign center_sel = sel_reg ? cfg.center_y : cfg.center_x;
    assign cordic_go  = start && proj;
    assign div_start  = (st_reg == M_DIVGO);

    // Rounded quotient, signed, plus principal point
    assign q_signed = neg_reg ? -ktta_pkg::wide_t'({2'b0, div_q[47:0]})
                              :  ktta_pkg::wide_t'({2'b0, div_q[47:0]});
    assign pix      = ktta_pkg::sat_s32(q_signed + ktta_pkg::widen_u(center_sel));

    ktta_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (prod_reg + 64'(zd[31:1])),
        .divisor  ({1'b0, zd}),
        .done     (div_done),
        .quotient (div_q)
    );

    ktta_cordic u_pan (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cordic_go),
        .x_in    (pred[2]),
        .y_in    (pred[0]),
        .busy    (pan_busy),
        .angle   (pan_raw)
    );

    ktta_cordic u_tilt (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cordic_go),
        .x_in    (pred[2]),
        .y_in    (pred[1]),
        .busy    (tilt_busy),
        .angle   (tilt_raw)
    );

    // Control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg  <= M_IDLE;
            sel_reg <= 1'b0;
        end else begin
            unique case (st_reg)
                M_IDLE: begin
                    if (start) begin
                        sel_reg <= 1'b0;
                        st_reg  <= proj ? M_MUL : M_HOLD;
                    end
                end
                M_MUL:   st_reg <= M_DIVGO;
                M_DIVGO: st_reg <= M_DIVWAIT;
                M_DIVWAIT: begin
                    if (div_done) begin
                        sel_reg <= 1'b1;
                        st_reg  <= sel_reg ? M_HOLD : M_MUL;
                    end
                end
                M_HOLD: begin
                    if (res_valid && res_ready) begin
                        st_reg <= M_IDLE;
                    end
                end
                default: st_reg <= M_IDLE;
            endcase
        end
    end

    // Datapath
    always_ff @(posedge aclk) begin
        if (st_reg == M_IDLE && start) begin
            proj_reg <= proj;
            px_reg   <= ktta_pkg::sat_s32(ktta_pkg::widen_u(cfg.center_x));
            py_reg   <= ktta_pkg::sat_s32(ktta_pkg::widen_u(cfg.center_y));
        end
        if (st_reg == M_MUL) begin
            prod_reg <= 64'(p_mag) * 64'(focal_sel);
            neg_reg  <= p_sel[31];
        end
        if (st_reg == M_DIVWAIT && div_done) begin
            if (sel_reg) begin
                py_reg <= pix;
            end else begin
                px_reg <= pix;
            end
        end
    end

    assign res_valid = (st_reg == M_HOLD) && !pan_busy && !tilt_busy;
    assign pixel_x   = px_reg;
    assign pixel_y   = py_reg;
    assign pan_rad   = proj_reg ? pan_raw : 18'sd0;
    assign tilt_rad  = proj_reg ? tilt_raw : 18'sd0;

endmodule

[src/kalman_target_tracker_aim_core.sv]
// Top level of the 3D constant-velocity Kalman tracker with aim output.
// Depends on ktta_pkg, ktta_lane and ktta_merge.
//
//   channel   dir  payload (tdata, low bit first)                         width
//   s_        in   meas_x, meas_y, meas_z, time_ms                        128
//   m_        out  pred_x/y/z, pixel_x/y, pan_rad, tilt_rad, 4 zeros       200
//   cfg_      in   cfg_index selects register, cfg_wdata written on cfg_wen 32
//
// One item at a time. The bit-serial divider takes most of the time from accept
// to result: it runs twice in each lane (the two gains) and, with projection,
// twice in the merge stage.
// Reset is synchronous; no clearing pass.
// A finished result waits in the output register; the next item is taken as
// soon as the result has moved there, whatever m_tready does.
`timescale 1ns / 1ps

module kalman_target_tracker_aim_core (
    input  logic                              aclk,
    input  logic                              aresetn,
    // meas_x, meas_y, meas_z, time_ms
    input  logic [127:0]                      s_tdata,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // pred_x, pred_y, pred_z, pixel_x, pixel_y, pan_rad, tilt_rad, pad
    output logic [199:0]                      m_tdata,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    input  logic                              cfg_wen,
    input  logic [ktta_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [31:0]                       cfg_wdata
);

    localparam logic [1:0] T_IDLE  = 2'd0;
    localparam logic [1:0] T_DT    = 2'd1;
    localparam logic [1:0] T_LANE  = 2'd2;
    localparam logic [1:0] T_MERGE = 2'd3;

    // Configuration
    logic [31:0]    focal_x_reg;
    logic [31:0]    focal_y_reg;
    logic [31:0]    center_x_reg;
    logic [31:0]    center_y_reg;
    logic [16:0]    latency_reg;
    logic [31:0]    pos_noise_reg;
    logic [31:0]    vel_noise_reg;
    logic [31:0]    meas_noise_reg;

    logic [1:0]     t_state_reg;
    logic [31:0]    last_time_reg;
    logic           seen_reg;
    logic           first_reg;
    logic           reseed_reg;
    logic [31:0]    d_reg;
    logic [15:0]    dt_reg;
    logic           lstart_reg;
    logic           mstart_reg;
    logic           m_tvalid_reg;
    logic [199:0]   m_tdata_reg;
    ktta_pkg::q32s_t meas_reg [ktta_pkg::FIELD_AXES];

    logic                   s_accept;
    logic [31:0]            d_now;
    logic [24:0]            dt_num;
    logic [55:0]            dt_prod;
    logic [15:0]            dt_next;
    logic [ktta_pkg::FIELD_AXES-1:0] lane_done;
    ktta_pkg::q32s_t        pred [ktta_pkg::FIELD_AXES];
    ktta_pkg::lane_ctl_t    lane_ctl;
    ktta_pkg::lane_cfg_t    lane_cfg;
    ktta_pkg::proj_cfg_t    proj_cfg;
    logic                   res_valid;
    logic                   res_ready;
    ktta_pkg::q32s_t        pixel_x;
    ktta_pkg::q32s_t        pixel_y;
    logic signed [17:0]     pan_rad;
    logic signed [17:0]     tilt_rad;

    assign s_tready = (t_state_reg == T_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign d_now    = s_tdata[127:96] - last_time_reg;

    // round(d * 65536 / 1000) by reciprocal multiply
    assign dt_num  = {d_reg[8:0], 16'd0} + 25'd500;
    assign dt_prod = 56'(dt_num) * 56'(ktta_pkg::RECIP_1000);
    assign dt_next = (first_reg || reseed_reg) ? ktta_pkg::DT_DEFAULT : dt_prod[55:40];

    // Configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            focal_x_reg    <= '0;
            focal_y_reg    <= '0;
            center_x_reg   <= '0;
            center_y_reg   <= '0;
            latency_reg    <= '0;
            pos_noise_reg  <= ktta_pkg::POS_NOISE_RST;
            vel_noise_reg  <= ktta_pkg::VEL_NOISE_RST;
            meas_noise_reg <= ktta_pkg::MEAS_NOISE_RST;
        end else if (cfg_wen) begin
            unique case (cfg_index)
                ktta_pkg::CFG_FOCAL_X:    focal_x_reg    <= cfg_wdata;
                ktta_pkg::CFG_FOCAL_Y:    focal_y_reg    <= cfg_wdata;
                ktta_pkg::CFG_CENTER_X:   center_x_reg   <= cfg_wdata;
                ktta_pkg::CFG_CENTER_Y:   center_y_reg   <= cfg_wdata;
                ktta_pkg::CFG_LATENCY:    latency_reg    <= cfg_wdata[16:0];
                ktta_pkg::CFG_POS_NOISE:  pos_noise_reg  <= cfg_wdata;
                ktta_pkg::CFG_VEL_NOISE:  vel_noise_reg  <= cfg_wdata;
                ktta_pkg::CFG_MEAS_NOISE: meas_noise_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Item sequencing
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            t_state_reg   <= T_IDLE;
            last_time_reg <= '0;
            seen_reg      <= 1'b0;
            lstart_reg    <= 1'b0;
            mstart_reg    <= 1'b0;
        end else begin
            lstart_reg <= 1'b0;
            mstart_reg <= 1'b0;
            unique case (t_state_reg)
                T_IDLE: begin
                    if (s_accept) begin
                        last_time_reg <= s_tdata[127:96];
                        seen_reg      <= 1'b1;
                        t_state_reg   <= T_DT;
                    end
                end
                T_DT: begin
                    lstart_reg  <= 1'b1;
                    t_state_reg <= T_LANE;
                end
                T_LANE: begin
                    if (&lane_done && !lstart_reg) begin
                        mstart_reg  <= 1'b1;
                        t_state_reg <= T_MERGE;
                    end
                end
                T_MERGE: begin
                    if (res_valid && res_ready) begin
                        t_state_reg <= T_IDLE;
                    end
                end
                default: t_state_reg <= T_IDLE;
            endcase
        end
    end

    // Item capture and step length
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            meas_reg[0] <= s_tdata[31:0];
            meas_reg[1] <= s_tdata[63:32];
            meas_reg[2] <= s_tdata[95:64];
            d_reg       <= d_now;
            first_reg   <= !seen_reg;
            reseed_reg  <= seen_reg && (d_now > ktta_pkg::DROPOUT_MS);
        end
        if (t_state_reg == T_DT) begin
            dt_reg <= dt_next;
        end
    end

    assign lane_ctl = '{start: lstart_reg, reseed: reseed_reg, dt: dt_reg};
    assign lane_cfg = '{pos_noise: pos_noise_reg, vel_noise: vel_noise_reg,
                        meas_noise: meas_noise_reg, latency: latency_reg};
    assign proj_cfg = '{focal_x: focal_x_reg, focal_y: focal_y_reg,
                        center_x: center_x_reg, center_y: center_y_reg};

    // Axis lanes; untracked axes predict zero
    for (genvar g = 0; g < ktta_pkg::FIELD_AXES; g++) begin : g_axis
        if (g < ktta_pkg::AXES) begin : g_lane
            ktta_lane u_lane (
                .aclk    (aclk),
                .aresetn (aresetn),
                .ctl     (lane_ctl),
                .cfg     (lane_cfg),
                .meas    (meas_reg[g]),
                .done    (lane_done[g]),
                .pred    (pred[g])
            );
        end else begin : g_none
            assign lane_done[g] = 1'b1;
            assign pred[g]      = '0;
        end
    end

    ktta_merge u_merge (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (mstart_reg),
        .pred      (pred),
        .cfg       (proj_cfg),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .pixel_x   (pixel_x),
        .pixel_y   (pixel_y),
        .pan_rad   (pan_rad),
        .tilt_rad  (tilt_rad)
    );

    // Output register
    assign res_ready = !m_tvalid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (res_ready) begin
            m_tvalid_reg <= res_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid && res_ready) begin
            m_tdata_reg <= {4'd0, tilt_rad, pan_rad, pixel_y, pixel_x,
                            pred[2], pred[1], pred[0]};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

[src/ktta_checker.sv]
// Port-level checks for the tracker top level, attached by bind.
// Depends on ktta_pkg and kalman_target_tracker_aim_core.
`timescale 1ns / 1ps

module ktta_checker (
    input logic          aclk,
    input logic          aresetn,
    input logic          s_tvalid,
    input logic          s_tready,
    input logic [199:0]  m_tdata,
    input logic          m_tvalid,
    input logic          m_tready
);

    // A waiting result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // Reset leaves an empty, ready block
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid && s_tready)
        else $error("not idle after reset");

    // One item in flight
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second item taken while busy");

    // Angles within a quarter turn
    a_angle_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |->
            $signed(m_tdata[177:160]) <= ktta_pkg::HALF_PI_Q &&
            $signed(m_tdata[177:160]) >= -ktta_pkg::HALF_PI_Q &&
            $signed(m_tdata[195:178]) <= ktta_pkg::HALF_PI_Q &&
            $signed(m_tdata[195:178]) >= -ktta_pkg::HALF_PI_Q)
        else $error("angle out of range");

    // No projection when depth is at or below one: angles zero
    a_near_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && ($signed(m_tdata[95:64]) <= $signed(ktta_pkg::ONE_Q)) |->
            m_tdata[195:160] == 36'd0)
        else $error("angles set without projection");

endmodule

bind kalman_target_tracker_aim_core ktta_checker u_ktta_checker (.*);

[tb/ktta_tracker_checker.sv]
// Tracking checker for the Kalman target tracker: watches both stream channels and the
// register port, predicts each result from its own copy of the filter state, compares fields.
// Depends on ktta_pkg for the register indexes.
`timescale 1ns / 1ps

module ktta_tracker_checker (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic [127:0] s_tdata,
    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic [199:0] m_tdata,
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic         cfg_wen,
    input  logic [2:0]   cfg_index,
    input  logic [31:0]  cfg_wdata,
    output int           fail_count,
    output int           pending_count
);

    typedef struct packed {
        logic [31:0] px, py, pz, pix_x, pix_y;
        logic [17:0] pan, tilt;
    } aim_t;

    localparam longint S_MAX = 64'sd2147483647;
    localparam longint S_MIN = -64'sd2147483648;
    localparam longint U_MAX = 64'sd4294967295;

    // Register shadow and filter state
    longint reg_shadow [8];
    longint trk_pos [3], trk_vel [3], var_p [3], cov_pv [3], var_v [3];
    logic [31:0] prev_ms;
    bit     first_seen;
    aim_t   aim_queue [$];

    function automatic longint mag64(longint v);
        return v < 0 ? -v : v;
    endfunction

    // Q16.16 product, rounded half away from zero
    function automatic longint qmul(longint a, longint b);
        longint r;
        r = (mag64(a) * mag64(b) + 32768) >>> 16;
        return ((a < 0) != (b < 0)) ? -r : r;
    endfunction

    function automatic longint sat32(longint v);
        return v > S_MAX ? S_MAX : (v < S_MIN ? S_MIN : v);
    endfunction

    function automatic longint clampu(longint v);
        return v < 0 ? 0 : (v > U_MAX ? U_MAX : v);
    endfunction

    function automatic longint fshr(longint v, int s);
        return v >>> s;
    endfunction

    // num * q / den, rounded; magnitudes may exceed 64 bits so work wide
    function automatic longint qdiv(longint num, longint q, longint den);
        logic [127:0] w;
        longint r;
        w = (128'(mag64(num)) * 128'(q) + 128'(den / 2)) / 128'(den);
        r = (w > 128'h7fffffffffffffff) ? 64'sh7fffffffffffffff : longint'(w[63:0]);
        return num < 0 ? -r : r;
    endfunction

    function automatic longint aim_atan(longint y, longint x);
        longint ang, xs, ys;
        longint lut [16] = '{51472, 30386, 16055, 8150, 4091, 2047, 1024, 512,
                             256, 128, 64, 32, 16, 8, 4, 2};
        ang = 0;
        for (int i = 0; i < 16; i++) begin
            xs = fshr(x, i);
            ys = fshr(y, i);
            if (y > 0) begin
                x += ys; y -= xs; ang += lut[i];
            end else if (y < 0) begin
                x -= ys; y += xs; ang -= lut[i];
            end
        end
        if (ang > 102944) ang = 102944;
        if (ang < -102944) ang = -102944;
        return ang;
    endfunction

    // Advance the filter by one measurement and return the aim result
    function automatic aim_t track_step(logic [127:0] d);
        logic [31:0] t, gap;
        longint dt, z, p, v, a, b, c, pp, ap, bp, cp, s, k1, k2, e, np, nv, pxv, pyv;
        longint pr [3];
        bit reseed;
        aim_t res;
        t = d[127:96];
        gap = t - prev_ms;
        dt = 1049;
        reseed = 0;
        if (first_seen) begin
            if (gap > ktta_pkg::DROPOUT_MS) reseed = 1;
            else dt = (longint'(gap) * 65536 + 500) / 1000;
        end
        prev_ms = t;
        first_seen = 1;
        for (int ax = 0; ax < 3; ax++) begin
            z = longint'($signed(d[ax*32 +: 32]));
            if (reseed) begin
                trk_pos[ax] = z; trk_vel[ax] = 0;
            end
            p = trk_pos[ax]; v = trk_vel[ax];
            a = var_p[ax]; b = cov_pv[ax]; c = var_v[ax];
            pp = p + qmul(dt, v);
            ap = clampu(a + 2 * qmul(dt, b) + qmul(dt, qmul(dt, c)) +
                        reg_shadow[ktta_pkg::CFG_POS_NOISE]);
            bp = sat32(b + qmul(dt, c));
            cp = clampu(c + reg_shadow[ktta_pkg::CFG_VEL_NOISE]);
            s = ap + reg_shadow[ktta_pkg::CFG_MEAS_NOISE];
            k1 = 0; k2 = 0;
            if (s != 0) begin
                k1 = qdiv(ap, 65536, s);
                k2 = sat32(qdiv(bp, 65536, s));
            end
            e = sat32(z - pp);
            np = sat32(pp + qmul(k1, e));
            nv = sat32(v + qmul(k2, e));
            trk_pos[ax] = np;
            trk_vel[ax] = nv;
            var_p[ax] = clampu(ap - qmul(k1, ap));
            cov_pv[ax] = sat32(bp - qmul(k1, bp));
            var_v[ax] = clampu(cp - qmul(k2, bp));
            pr[ax] = sat32(np + qmul(nv, reg_shadow[ktta_pkg::CFG_LATENCY]));
        end
        res.pan = '0;
        res.tilt = '0;
        if (pr[2] > 65536) begin
            pxv = sat32(qdiv(pr[0], reg_shadow[ktta_pkg::CFG_FOCAL_X], pr[2]) +
                        reg_shadow[ktta_pkg::CFG_CENTER_X]);
            pyv = sat32(qdiv(pr[1], reg_shadow[ktta_pkg::CFG_FOCAL_Y], pr[2]) +
                        reg_shadow[ktta_pkg::CFG_CENTER_Y]);
            res.pan = 18'(aim_atan(pr[0], pr[2]));
            res.tilt = 18'(aim_atan(pr[1], pr[2]));
        end else begin
            pxv = sat32(reg_shadow[ktta_pkg::CFG_CENTER_X]);
            pyv = sat32(reg_shadow[ktta_pkg::CFG_CENTER_Y]);
        end
        res.px = 32'(pr[0]); res.py = 32'(pr[1]); res.pz = 32'(pr[2]);
        res.pix_x = 32'(pxv); res.pix_y = 32'(pyv);
        return res;
    endfunction

    task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] got_v);
        if (exp_v !== got_v) begin
            $error("%s mismatch: expected %0h, got %0h", name, exp_v, got_v);
            fail_count++;
        end
    endtask

    initial begin
        fail_count = 0;
        pending_count = 0;
    end

    always @(posedge aclk) begin
        aim_t want, got;
        if (!aresetn) begin
            for (int i = 0; i < 8; i++) reg_shadow[i] = 0;
            reg_shadow[ktta_pkg::CFG_POS_NOISE] = 66;
            reg_shadow[ktta_pkg::CFG_VEL_NOISE] = 327680;
            reg_shadow[ktta_pkg::CFG_MEAS_NOISE] = 66;
            for (int i = 0; i < 3; i++) begin
                trk_pos[i] = 0; trk_vel[i] = 0; cov_pv[i] = 0;
                var_p[i] = 65536; var_v[i] = 65536;
            end
            prev_ms = '0;
            first_seen = 0;
            aim_queue.delete();
        end else begin
            if (cfg_wen)
                reg_shadow[cfg_index] = (cfg_index == ktta_pkg::CFG_LATENCY) ?
                    longint'(cfg_wdata[16:0]) : longint'(cfg_wdata);
            // compare an accepted result with the oldest prediction
            if (m_tvalid && m_tready) begin
                if (aim_queue.size() == 0) begin
                    $error("result item with no prediction waiting");
                    fail_count++;
                end else begin
                    want = aim_queue.pop_front();
                    got.px = m_tdata[31:0];     got.py = m_tdata[63:32];
                    got.pz = m_tdata[95:64];    got.pix_x = m_tdata[127:96];
                    got.pix_y = m_tdata[159:128];
                    got.pan = m_tdata[177:160]; got.tilt = m_tdata[195:178];
                    check_field("pred_x", want.px, got.px);
                    check_field("pred_y", want.py, got.py);
                    check_field("pred_z", want.pz, got.pz);
                    check_field("pixel_x", want.pix_x, got.pix_x);
                    check_field("pixel_y", want.pix_y, got.pix_y);
                    check_field("pan_rad", 32'(want.pan), 32'(got.pan));
                    check_field("tilt_rad", 32'(want.tilt), 32'(got.tilt));
                end
            end
            if (s_tvalid && s_tready) aim_queue.push_back(track_step(s_tdata));
        end
        pending_count = aim_queue.size();
    end
endmodule

[tb/tb_kalman_target_tracker_aim_core.sv]
// Testbench top for the Kalman target tracker: clock, reset, register phases and
// measurement stimulus. Depends on ktta_pkg, the block and ktta_tracker_checker.
`timescale 1ns / 1ps

module tb_kalman_target_tracker_aim_core;

    localparam int CYCLE_LIMIT = 2000000;

    logic         aclk = 0;
    logic         aresetn = 0;
    logic [127:0] s_tdata = '0;
    logic         s_tvalid = 0;
    logic         s_tready;
    logic [199:0] m_tdata;
    logic         m_tvalid;
    logic         m_tready = 0;
    logic         cfg_wen = 0;
    logic [2:0]   cfg_index = ktta_pkg::CFG_FOCAL_X;
    logic [31:0]  cfg_wdata = '0;
    int           fail_count, pending_count;
    int           cycle_count = 0;
    bit           calm = 0;      // no idling on either side
    bit           hold_off = 0;  // receiver stall request
    logic [31:0]  clock_ms = 0;

    always begin
        #5 aclk = 1;
        #5 aclk = 0;
    end

    kalman_target_tracker_aim_core uut (.*);

    ktta_tracker_checker chk (.*);

    // Run guard
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // Receiver: random stalls, plus one long hold-off
    always @(posedge aclk) begin
        if (!aresetn || hold_off) m_tready <= 0;
        else m_tready <= calm ? 1'b1 : ($urandom_range(99) >= 14);
    end

    task automatic write_reg(logic [2:0] idx, logic [31:0] val);
        @(posedge aclk);
        cfg_wen <= 1; cfg_index <= idx; cfg_wdata <= val;
        @(posedge aclk);
        cfg_wen <= 0;
    endtask

    // Offer one measurement and wait for its acceptance; valid stays up afterwards
    task automatic send_meas(logic [31:0] x, logic [31:0] y, logic [31:0] z, logic [31:0] t);
        while (!calm && $urandom_range(99) < 14) begin
            s_tvalid <= 0;
            @(posedge aclk);
        end
        s_tvalid <= 1;
        s_tdata <= {t, z, y, x};
        do @(posedge aclk); while (!s_tready);
    endtask

    // Tracking-like measurement: mostly small steps, some dropouts and noise
    task automatic send_track(int kind);
        logic [31:0] x, y, z;
        int r;
        r = $urandom_range(99);
        if (r < 80) clock_ms = clock_ms + $urandom_range(500, 1);
        else if (r < 90) clock_ms = clock_ms + $urandom_range(5000, 501);
        else if (r < 95) clock_ms = clock_ms - $urandom_range(100, 1);
        else clock_ms = $urandom;
        if (kind < 85) begin
            x = $signed($urandom_range(1 << 20)) - (1 << 19) ;
            y = $signed($urandom_range(1 << 20)) - (1 << 19);
            z = $urandom_range(1 << 22, 1 << 15);
        end else begin
            x = $urandom; y = $urandom; z = $urandom;
        end
        send_meas(x, y, z, clock_ms);
    endtask

    // Stop offering and wait until every accepted item has left
    task automatic drain();
        s_tvalid <= 0;
        @(posedge aclk);
        while (pending_count != 0) @(posedge aclk);
        repeat (400) @(posedge aclk);
    endtask

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1;

        // Directed: reset registers, first item, zero dt, dropout, backward time
        send_meas(32'h0001_0000, 32'h0002_0000, 32'h0005_0000, 32'd100);
        send_meas(32'h0001_0000, 32'h0002_0000, 32'h0005_0000, 32'd100);
        send_meas(32'h0001_8000, 32'h0001_0000, 32'h0005_0000, 32'd600);
        send_meas(32'h0002_0000, 32'h0001_0000, 32'h0005_0000, 32'd1200);
        send_meas(32'h0002_0000, 32'h0001_0000, 32'h0005_0000, 32'd1100);
        send_meas(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff);
        send_meas(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'd0);
        send_meas(32'h0000_0000, 32'h0000_0000, 32'h0001_0000, 32'd2000);
        send_meas(32'hffff_ffff, 32'h0000_0001, 32'h0001_0001, 32'd2500);
        drain();

        // Camera-like settings with latency
        write_reg(ktta_pkg::CFG_FOCAL_X, 32'd800 << 16);
        write_reg(ktta_pkg::CFG_FOCAL_Y, 32'd780 << 16);
        write_reg(ktta_pkg::CFG_CENTER_X, 32'd320 << 16);
        write_reg(ktta_pkg::CFG_CENTER_Y, 32'd240 << 16);
        write_reg(ktta_pkg::CFG_LATENCY, 32'd3277);
        send_meas(32'h0001_0000, 32'hffff_0000, 32'h0004_0000, 32'd9000);
        send_meas(32'h0001_1000, 32'hfffe_f000, 32'h0004_0000, 32'd9016);
        send_meas(32'h0001_2000, 32'hfffe_e000, 32'h0003_0000, 32'd9032);
        send_meas(32'hfff0_0000, 32'h0010_0000, 32'h0002_0000, 32'd9048);
        drain();

        // Extremes: zero noise (zero innovation variance), full latency, top registers
        write_reg(ktta_pkg::CFG_POS_NOISE, 32'd0);
        write_reg(ktta_pkg::CFG_VEL_NOISE, 32'd0);
        write_reg(ktta_pkg::CFG_MEAS_NOISE, 32'd0);
        write_reg(ktta_pkg::CFG_LATENCY, 32'd65536);
        write_reg(ktta_pkg::CFG_FOCAL_X, 32'hffff_ffff);
        write_reg(ktta_pkg::CFG_CENTER_Y, 32'hffff_ffff);
        for (int i = 0; i < 8; i++) send_track(90);
        drain();
        write_reg(ktta_pkg::CFG_POS_NOISE, 32'hffff_ffff);
        write_reg(ktta_pkg::CFG_VEL_NOISE, 32'hffff_ffff);
        write_reg(ktta_pkg::CFG_MEAS_NOISE, 32'hffff_ffff);
        write_reg(ktta_pkg::CFG_FOCAL_Y, 32'hffff_ffff);
        write_reg(ktta_pkg::CFG_CENTER_X, 32'hffff_ffff);
        for (int i = 0; i < 4; i++) send_track(90);
        drain();

        // Random phases with random register settings
        for (int ph = 0; ph < 6; ph++) begin
            write_reg(ktta_pkg::CFG_FOCAL_X, $urandom_range(2000 << 16));
            write_reg(ktta_pkg::CFG_FOCAL_Y, $urandom_range(2000 << 16));
            write_reg(ktta_pkg::CFG_CENTER_X,
                      ph == 5 ? $urandom : $urandom_range(1000 << 16));
            write_reg(ktta_pkg::CFG_CENTER_Y,
                      ph == 5 ? $urandom : $urandom_range(1000 << 16));
            write_reg(ktta_pkg::CFG_LATENCY, $urandom_range(65536));
            write_reg(ktta_pkg::CFG_POS_NOISE,
                      ph == 4 ? $urandom : $urandom_range(1 << 16));
            write_reg(ktta_pkg::CFG_VEL_NOISE,
                      ph == 4 ? $urandom : $urandom_range(1 << 20));
            write_reg(ktta_pkg::CFG_MEAS_NOISE,
                      ph == 4 ? $urandom : $urandom_range(1 << 16));
            calm = (ph == 2);
            // one long receiver hold-off while the sender keeps offering
            if (ph == 1) begin
                fork
                    begin
                        hold_off = 1;
                        repeat (3000) @(posedge aclk);
                        hold_off = 0;
                    end
                    for (int i = 0; i < 250; i++) send_track($urandom_range(99));
                join
            end else begin
                for (int i = 0; i < 250; i++) send_track($urandom_range(99));
            end
            calm = 0;
            drain();
        end

        if (fail_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end
endmodule

[sim.f]
src/ktta_pkg.sv
src/ktta_div.sv
src/ktta_cordic.sv
src/ktta_lane.sv
src/ktta_merge.sv
src/kalman_target_tracker_aim_core.sv
src/ktta_checker.sv
tb/ktta_tracker_checker.sv
tb/tb_kalman_target_tracker_aim_core.sv
